[rtl/assert_macros.svh]
// Assertion macros used by the scheduler back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/mlfq_pkg.sv]
package mlfq_pkg;

  localparam int unsigned Threads = 64;
  localparam int unsigned Levels = 128;
  localparam int unsigned TidW = 6;
  localparam int unsigned LvlW = 7;
  localparam int unsigned CntW = 7;
  localparam int unsigned QDepth = 2;

  localparam logic [2:0] OpRegister = 3'd0;
  localparam logic [2:0] OpEnqueue = 3'd1;
  localparam logic [2:0] OpDequeue = 3'd2;
  localparam logic [2:0] OpSwitch = 3'd3;
  localparam logic [2:0] OpTick = 3'd4;

  localparam logic [1:0] StOk = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StQueued = 2'd2;

  localparam logic [1:0] CfgQuantum = 2'd0;
  localparam logic [1:0] CfgAging = 2'd1;
  localparam logic [1:0] CfgMinPrio = 2'd2;

  // One command as decoded by the front part.
  typedef struct packed {
    logic [2:0] op;
    logic [TidW-1:0] tid;
    logic [LvlW-1:0] prio;
    logic ts;
    logic run;
  } cmd_t;

  // One result item.
  typedef struct packed {
    logic [1:0] status;
    logic [CntW-1:0] count;
    logic resched;
    logic idle;
    logic [TidW-1:0] thread;
  } res_t;

endpackage

[rtl/mlfq_ram.sv]
module mlfq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/mlfq_front.sv]
module mlfq_front import mlfq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  output logic        q_valid_o,
  input  logic        q_pop_i,
  output cmd_t        q_cmd_o
);

  cmd_t cmd_in;
  cmd_t fifo_q [QDepth];
  logic wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic push;

  // Field unpacking; priority needs no saturation at 128 levels.
  always_comb begin
    cmd_in.op   = s_axis_tdata[2:0];
    cmd_in.tid  = s_axis_tdata[8:3];
    cmd_in.prio = s_axis_tdata[15:9];
    cmd_in.ts   = s_axis_tdata[16];
    cmd_in.run  = s_axis_tdata[17];
  end

  assign s_axis_tready = (cnt_q != 2'(QDepth));
  assign push = s_axis_tvalid && s_axis_tready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o = fifo_q[rd_ptr_q];

  // Payload storage of the command queue.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cmd_in;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (q_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

endmodule

[rtl/mlfq_back.sv]
`include "assert_macros.svh"
module mlfq_back import mlfq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        q_valid_i,
  output logic        q_pop_o,
  input  cmd_t        q_cmd_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output res_t        res_o
);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DEC, S_REG, S_ENQ0, S_ENQ1, S_ENQ2, S_DQ0, S_DQ1, S_DQW, S_DQU,
    S_SW0, S_SWS, S_SW1, S_SW2, S_TK0, S_AGL, S_AGR, S_AGC, S_DONE
  } state_e;

  state_e state_q;
  cmd_t cmd_q;
  logic [15:0] quantum_q, aging_q;
  logic [LvlW-1:0] minp_q;
  logic [Threads-1:0] ts_q, queued_q;
  logic [Levels-1:0] ne_q;
  logic [TidW-1:0] cur_q;
  logic idle_q, resched_q;
  logic [16:0] qleft_q;
  logic [15:0] phase_q;
  logic [CntW-1:0] wcount_q;
  logic [1:0] status_q;
  logic [TidW-1:0] t_q, c_q, prev_q, head_q, tail_q;
  logic [LvlW-1:0] lvl_q;
  logic has_prev_q, sw_app_q;
  logic [TidW:0] steps_q;
  logic out_v_q;
  res_t out_q;

  // Link and level tables in RAM.
  logic nl_we, hd_we, tl_we;
  logic [TidW-1:0] nl_wa, nl_wd, nl_ra, nl_rd, hd_wd, hd_rd, tl_wd, tl_rd;
  logic [LvlW-1:0] hd_wa, tl_wa, lv_ra;

  // Base and effective priority tables in RAM, both read at one address.
  logic ep_we, bp_we;
  logic [TidW-1:0] ep_wa, ep_ra;
  logic [LvlW-1:0] ep_wd, ep_rd, bp_rd;

  mlfq_ram #(.Width(TidW), .Depth(Threads)) u_next (
    .clk_i, .we_i(nl_we), .waddr_i(nl_wa), .wdata_i(nl_wd), .raddr_i(nl_ra), .rdata_o(nl_rd));
  mlfq_ram #(.Width(TidW), .Depth(Levels)) u_head (
    .clk_i, .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd), .raddr_i(lv_ra), .rdata_o(hd_rd));
  mlfq_ram #(.Width(TidW), .Depth(Levels)) u_tail (
    .clk_i, .we_i(tl_we), .waddr_i(tl_wa), .wdata_i(tl_wd), .raddr_i(lv_ra), .rdata_o(tl_rd));
  mlfq_ram #(.Width(LvlW), .Depth(Threads)) u_eff (
    .clk_i, .we_i(ep_we), .waddr_i(ep_wa), .wdata_i(ep_wd), .raddr_i(ep_ra), .rdata_o(ep_rd));
  mlfq_ram #(.Width(LvlW), .Depth(Threads)) u_base (
    .clk_i, .we_i(bp_we), .waddr_i(ep_wa), .wdata_i(ep_wd), .raddr_i(ep_ra), .rdata_o(bp_rd));

  // Highest non-empty level by priority search.
  logic [LvlW-1:0] top_lvl;
  logic top_found;
  always_comb begin
    top_lvl = '0;
    top_found = 1'b0;
    for (int i = 0; i < Levels; i++) begin
      if (ne_q[i]) begin
        top_lvl = LvlW'(i);
        top_found = 1'b1;
      end
    end
  end

  // Lowest non-empty level at or above lvl_q, excluding the highest level, Levels - 1.
  logic [LvlW-1:0] age_lvl;
  logic age_found;
  always_comb begin
    age_lvl = '0;
    age_found = 1'b0;
    for (int i = Levels - 2; i >= 0; i--) begin
      if (ne_q[i] && (LvlW'(i) >= lvl_q)) begin
        age_lvl = LvlW'(i);
        age_found = 1'b1;
      end
    end
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;
  assign res_valid_o = out_v_q;
  assign res_o = out_q;

  // RAM port control; each read address is driven in the state before the one that uses the data.
  always_comb begin
    nl_we = 1'b0; nl_wa = t_q; nl_wd = '0; nl_ra = c_q;
    hd_we = 1'b0; hd_wa = lvl_q; hd_wd = t_q;
    tl_we = 1'b0; tl_wa = lvl_q; tl_wd = t_q;
    lv_ra = lvl_q;
    ep_we = 1'b0; bp_we = 1'b0; ep_wa = t_q; ep_wd = cmd_q.prio; ep_ra = cur_q;
    unique case (state_q)
      S_CLR: begin
        ep_we = 1'b1; bp_we = 1'b1; ep_wa = c_q; ep_wd = '0;
      end
      S_IDLE: ep_ra = q_cmd_i.tid;
      S_REG: begin
        ep_we = !queued_q[t_q]; bp_we = !queued_q[t_q];
      end
      S_ENQ1: begin
        nl_we = 1'b1; nl_wa = t_q; nl_wd = '0;
      end
      S_ENQ2: begin
        if (ne_q[lvl_q]) begin
          nl_we = 1'b1; nl_wa = tl_rd; nl_wd = t_q;
        end else begin
          hd_we = 1'b1;
        end
        tl_we = 1'b1;
      end
      S_DQ1: nl_ra = hd_rd;
      S_DQW: nl_ra = (c_q == t_q) ? c_q : nl_rd;
      S_DQU: begin
        if (!has_prev_q) begin
          hd_we = !(c_q == tail_q); hd_wd = nl_rd;
        end else begin
          nl_we = 1'b1; nl_wa = prev_q; nl_wd = nl_rd;
          tl_we = (c_q == tail_q); tl_wd = prev_q;
        end
      end
      S_SWS: lv_ra = top_lvl;
      S_SW1: nl_ra = hd_rd;
      S_SW2: begin
        hd_we = !(head_q == tail_q); hd_wd = nl_rd;
      end
      S_TK0: begin
        ep_wa = cur_q; ep_wd = ep_rd - 1'b1;
        ep_we = !idle_q && (qleft_q <= 17'd1) && ts_q[cur_q] && (ep_rd > minp_q);
      end
      S_AGL: lv_ra = age_lvl;
      S_AGR: begin
        nl_ra = hd_rd; ep_ra = hd_rd;
      end
      S_AGC: begin
        nl_ra = nl_rd; ep_ra = nl_rd;
        ep_wa = c_q; ep_wd = ep_rd + 1'b1;
        ep_we = ts_q[c_q] && (ep_rd < bp_rd);
      end
      default: ;
    endcase
  end

  // Sequencer carrying out one command at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      quantum_q <= 16'd10; aging_q <= 16'd100; minp_q <= '0;
      ts_q <= '0; queued_q <= '0; ne_q <= '0;
      cur_q <= '0; idle_q <= 1'b1; resched_q <= 1'b0;
      qleft_q <= '0; phase_q <= '0; wcount_q <= '0;
      out_v_q <= 1'b0;
      cmd_q <= '0; status_q <= StOk; t_q <= '0; c_q <= '0; prev_q <= '0;
      head_q <= '0; tail_q <= '0; lvl_q <= '0; has_prev_q <= 1'b0;
      sw_app_q <= 1'b0; steps_q <= '0; out_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgQuantum: quantum_q <= cfg_data_i;
          CfgAging:   aging_q <= cfg_data_i;
          CfgMinPrio: minp_q <= cfg_data_i[LvlW-1:0];
          default: ;
        endcase
      end
      if (out_v_q && res_ready_i && (state_q != S_DONE)) out_v_q <= 1'b0;
      unique case (state_q)
        // Zero both priority tables, one thread a cycle.
        S_CLR: begin
          if (c_q == TidW'(Threads - 1)) begin
            c_q <= '0; state_q <= S_IDLE;
          end else c_q <= c_q + 1'b1;
        end
        S_IDLE: if (q_valid_i) begin
          cmd_q <= q_cmd_i;
          state_q <= S_DEC;
        end
        S_DEC: begin
          status_q <= StOk;
          t_q <= cmd_q.tid;
          lvl_q <= ep_rd;
          unique case (cmd_q.op)
            OpRegister: state_q <= S_REG;
            OpEnqueue:  state_q <= S_ENQ0;
            OpDequeue:  state_q <= S_DQ0;
            OpSwitch:   state_q <= S_SW0;
            OpTick:     state_q <= S_TK0;
            default:    state_q <= S_DONE;
          endcase
        end
        S_REG: begin
          if (queued_q[t_q]) status_q <= StQueued;
          else ts_q[t_q] <= cmd_q.ts;
          state_q <= S_DONE;
        end
        S_ENQ0: begin
          if (queued_q[t_q]) begin
            status_q <= StQueued; state_q <= S_DONE;
          end else begin
            sw_app_q <= 1'b0; state_q <= S_ENQ1;
          end
        end
        S_ENQ1: state_q <= S_ENQ2;
        S_ENQ2: begin
          tail_q <= t_q;
          ne_q[lvl_q] <= 1'b1;
          queued_q[t_q] <= 1'b1;
          wcount_q <= wcount_q + 1'b1;
          if (sw_app_q) state_q <= S_SWS;
          else begin
            // The data port holds the running thread's effective priority here.
            if (idle_q || (lvl_q > ep_rd)) resched_q <= 1'b1;
            state_q <= S_DONE;
          end
        end
        S_DQ0: begin
          if (!queued_q[t_q] || !ne_q[lvl_q]) begin
            status_q <= StNotFound; state_q <= S_DONE;
          end else state_q <= S_DQ1;
        end
        S_DQ1: begin
          c_q <= hd_rd; tail_q <= tl_rd; has_prev_q <= 1'b0;
          steps_q <= '0; state_q <= S_DQW;
        end
        S_DQW: begin
          if (c_q == t_q) state_q <= S_DQU;
          else if ((c_q == tail_q) || (steps_q == (TidW+1)'(Threads - 1))) begin
            status_q <= StNotFound; state_q <= S_DONE;
          end else begin
            prev_q <= c_q; has_prev_q <= 1'b1;
            c_q <= nl_rd; steps_q <= steps_q + 1'b1;
          end
        end
        S_DQU: begin
          if (!has_prev_q && (c_q == tail_q)) ne_q[lvl_q] <= 1'b0;
          queued_q[t_q] <= 1'b0;
          wcount_q <= wcount_q - 1'b1;
          state_q <= S_DONE;
        end
        S_SW0: begin
          resched_q <= 1'b0;
          if (cmd_q.run && !idle_q && !queued_q[cur_q]) begin
            t_q <= cur_q; lvl_q <= ep_rd; sw_app_q <= 1'b1;
            state_q <= S_ENQ1;
          end else state_q <= S_SWS;
        end
        S_SWS: begin
          if (!top_found) begin
            if (!idle_q) begin
              idle_q <= 1'b1; cur_q <= '0; qleft_q <= {1'b0, quantum_q};
            end
            state_q <= S_DONE;
          end else begin
            lvl_q <= top_lvl; state_q <= S_SW1;
          end
        end
        S_SW1: begin
          head_q <= hd_rd; tail_q <= tl_rd; c_q <= hd_rd; state_q <= S_SW2;
        end
        S_SW2: begin
          if (head_q == tail_q) ne_q[lvl_q] <= 1'b0;
          queued_q[head_q] <= 1'b0;
          wcount_q <= wcount_q - 1'b1;
          if (idle_q || (head_q != cur_q)) begin
            idle_q <= 1'b0; cur_q <= head_q; qleft_q <= {1'b0, quantum_q};
          end
          state_q <= S_DONE;
        end
        S_TK0: begin
          if ((phase_q + 16'd1) >= aging_q) phase_q <= '0;
          else phase_q <= phase_q + 16'd1;
          if (idle_q) begin
            if (wcount_q != '0) resched_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            if (qleft_q <= 17'd1) begin
              qleft_q <= '0;
              resched_q <= 1'b1;
            end else qleft_q <= qleft_q - 1'b1;
            if ((phase_q + 16'd1) >= aging_q) begin
              lvl_q <= '0; state_q <= S_AGL;
            end else state_q <= S_DONE;
          end
        end
        S_AGL: begin
          if (!age_found) state_q <= S_DONE;
          else begin
            lvl_q <= age_lvl; state_q <= S_AGR;
          end
        end
        S_AGR: begin
          c_q <= hd_rd; tail_q <= tl_rd; steps_q <= '0; state_q <= S_AGC;
        end
        S_AGC: begin
          if ((c_q == tail_q) || (steps_q == (TidW+1)'(Threads - 1))) begin
            if (lvl_q == LvlW'(Levels - 2)) state_q <= S_DONE;
            else begin
              lvl_q <= lvl_q + 1'b1; state_q <= S_AGL;
            end
          end else begin
            c_q <= nl_rd; steps_q <= steps_q + 1'b1;
          end
        end
        S_DONE: if (!out_v_q || res_ready_i) begin
          out_v_q <= 1'b1;
          out_q.thread <= idle_q ? '0 : cur_q;
          out_q.idle <= idle_q;
          out_q.resched <= resched_q;
          out_q.count <= wcount_q;
          out_q.status <= status_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_count_range, clk_i, rst_ni, 1'b1, wcount_q <= CntW'(Threads))
  `ASSERT_IMPL(a_idle_thread, clk_i, rst_ni, out_v_q && out_q.idle, out_q.thread == '0)
  `ASSERT_NEXT(a_pop_dec, clk_i, rst_ni, q_pop_o, state_q == S_DEC)

endmodule

[rtl/mlfq_run_queue_scheduler.sv]
// Multilevel feedback queue scheduler for one CPU.
// Commands arrive on the s_axis channel: opcode, thread id, requested priority,
// timeshare flag and still-runnable flag packed in tdata. Each command makes one
// result on m_axis: running thread, idle flag, reschedule request, count of
// waiting threads and status. Configuration registers (quantum, aging period,
// minimum priority) are written through cfg_we_i, cfg_idx_i and cfg_data_i.
// A two-entry command queue separates the input from a sequencer that carries
// the commands out one at a time. A dequeue walks its level's list at one thread
// a cycle, and a tick with an aging pass visits each non-empty level below the
// highest and each thread in it, one thread a cycle within a level.
// The walks are bound by the single read port of the link memory.
// After reset all queues are empty, the CPU is idle, and the registers hold
// quantum 10, aging period 100 and minimum priority 0. The priority tables are
// zeroed, thread by thread, before the first command is taken; link tables are
// not cleared. A stalled receiver holds the result in the output register; the
// sequencer then waits and the command queue fills before s_axis_tready drops.
module mlfq_run_queue_scheduler import mlfq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // opcode[2:0], thread_id[8:3], priority_req[15:9], timeshare[16],
  // still_runnable[17], zero fill[23:18]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // running_thread[5:0], running_idle[6], resched_req[7],
  // queued_count[14:8], status[16:15], zero fill[23:17]
  output logic [23:0] m_axis_tdata
);

  logic q_valid, q_pop;
  cmd_t q_cmd;
  res_t res;

  mlfq_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_cmd_o(q_cmd));

  mlfq_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_cmd_i(q_cmd),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res));

  assign m_axis_tdata = {7'd0, res};

endmodule
